[src/fpdt_pkg.sv]
package fpdt_pkg;

  // Width of the largest scale factor, ten to the ninth.
  localparam int SC_W = 30;
  // Decimal digits held for the integer part and for the fraction part.
  localparam int INT_DIGITS = 10;
  localparam int FRAC_DIGITS = 9;
  localparam int MAX_PREC = 9;

  localparam logic [6:0] CH_ZERO = 7'd48;
  localparam logic [6:0] CH_DOT = 7'd46;
  localparam logic [6:0] CH_MINUS = 7'd45;

  typedef logic [3:0] upc_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_MUL,
    OP_ROUND,
    OP_DABBLE,
    OP_SCAN,
    OP_SIGN,
    OP_INT,
    OP_DOT,
    OP_FRAC,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOSTART,
    C_CNT_NZ,
    C_LIDX_NZ,
    C_FZ,
    C_FIDX_NZ
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctl_t;

  function automatic logic [SC_W-1:0] pow_ten(input logic [3:0] p);
    logic [SC_W-1:0] v;
    unique case (p)
      4'd0: v = 30'd1;
      4'd1: v = 30'd10;
      4'd2: v = 30'd100;
      4'd3: v = 30'd1000;
      4'd4: v = 30'd10000;
      4'd5: v = 30'd100000;
      4'd6: v = 30'd1000000;
      4'd7: v = 30'd10000000;
      4'd8: v = 30'd100000000;
      default: v = 30'd1000000000;
    endcase
    return v;
  endfunction

  // Microprogram: one control word per step. A step whose condition holds
  // jumps to its target, otherwise the program moves to the next step.
  function automatic ctl_t ucode(input upc_t a);
    ctl_t c;
    unique case (a)
      4'd0: c = '{OP_IDLE, C_NOSTART, 4'd0};
      4'd1: c = '{OP_MUL, C_NEVER, 4'd0};
      4'd2: c = '{OP_ROUND, C_NEVER, 4'd0};
      4'd3: c = '{OP_DABBLE, C_CNT_NZ, 4'd3};
      4'd4: c = '{OP_SCAN, C_NEVER, 4'd0};
      4'd5: c = '{OP_SIGN, C_NEVER, 4'd0};
      4'd6: c = '{OP_INT, C_LIDX_NZ, 4'd6};
      4'd7: c = '{OP_DOT, C_FZ, 4'd0};
      4'd8: c = '{OP_FRAC, C_FIDX_NZ, 4'd8};
      default: c = '{OP_NOP, C_ALWAYS, 4'd0};
    endcase
    return c;
  endfunction

endpackage

[src/fixed_point_to_decimal_text.sv]
// After the start transaction is accepted, the sequencer multiplies, rounds, converts to BCD
// and scans the digits before the first character, a minus sign if one leads, is shown.
// A new number is taken only when idle again. The binary to BCD conversion is bit-serial, one
// bit per cycle over max(integer width plus one, scale width); characters come one per cycle.
// Results cannot be stalled: each character is shown for exactly one cycle with char_valid.
// Reset (rst, synchronous, active high) returns the sequencer to its idle step, drops
// char_valid and sets frac_digits to 2.
module fixed_point_to_decimal_text
  import fpdt_pkg::*;
#(
  parameter int FRAC_BITS = 32,
  parameter int INT_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          is_negative,
  input  logic [INT_BITS+FRAC_BITS-1:0] magnitude,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [3:0]                    cfg_data,
  output logic                          char_valid,
  output logic [6:0]                    char_code,
  output logic                          last_char
);

  // The integer part may gain one bit from a rounding carry.
  localparam int IPW = INT_BITS + 1;
  // Number of shift steps of the conversion: enough for both parts.
  localparam int NSTEP = (IPW > SC_W) ? IPW : SC_W;
  localparam int CNT_W = $clog2(NSTEP);
  localparam int PW = FRAC_BITS + SC_W;

  // Configuration register, clamped to nine places as it is written.
  logic [3:0] frac_digits;

  // Sequencer.
  upc_t pc;
  upc_t pc_next;
  ctl_t ctl;
  logic taken;

  // Datapath registers.
  logic                    neg;
  logic [INT_BITS-1:0]     ip;
  logic [FRAC_BITS-1:0]    fr;
  logic [PW-1:0]           prod;
  logic [NSTEP-1:0]        isrc;
  logic [NSTEP-1:0]        fsrc;
  logic [4*INT_DIGITS-1:0] ibcd;
  logic [4*FRAC_DIGITS-1:0] fbcd;
  logic [CNT_W-1:0]        cnt;
  logic [3:0]              lidx;
  logic [3:0]              fidx;
  logic                    fnz;

  // The fraction loop walks from the first digit after the point to the last
  // non-zero one; it is held in ftop, registered at the scan step.
  logic [3:0] ftop;

  // Rounding: add half a unit of the last kept place, then take the scaled
  // fraction. A scaled fraction equal to the scale carries into the integer.
  logic [PW:0]       rsum;
  logic [SC_W:0]     fs;
  logic [SC_W-1:0]   sc;
  logic              rcarry;
  logic [IPW-1:0]    ipart;
  logic [SC_W-1:0]   fpart;

  // Shift-and-add-three conversion, one bit a step.
  logic [4*INT_DIGITS-1:0]  ibcd_adj;
  logic [4*FRAC_DIGITS-1:0] fbcd_adj;

  // Digit scan results.
  logic [3:0] lead_c;
  logic [3:0] ftop_c;
  logic       fnz_c;

  assign cfg_ready = 1'b1;
  assign busy = (pc != 4'd0);
  assign ctl = ucode(pc);

  assign sc = pow_ten(frac_digits);
  assign rsum = {1'b0, prod} + ((PW + 1)'(1) << (FRAC_BITS - 1));
  assign fs = rsum[FRAC_BITS +: SC_W + 1];
  assign rcarry = (fs == {1'b0, sc});
  assign ipart = {1'b0, ip} + IPW'(rcarry);
  assign fpart = rcarry ? '0 : fs[SC_W-1:0];

  always_comb begin
    for (int k = 0; k < INT_DIGITS; k++) begin
      ibcd_adj[4*k +: 4] = (ibcd[4*k +: 4] >= 4'd5) ? ibcd[4*k +: 4] + 4'd3
                                                      : ibcd[4*k +: 4];
    end
    for (int k = 0; k < FRAC_DIGITS; k++) begin
      fbcd_adj[4*k +: 4] = (fbcd[4*k +: 4] >= 4'd5) ? fbcd[4*k +: 4] + 4'd3
                                                      : fbcd[4*k +: 4];
    end
  end

  // The highest non-zero integer digit starts the text; the lowest non-zero
  // fraction digit ends it, which drops the trailing zeros. The scaled
  // fraction has frac_digits digits, so its digit k sits frac_digits-1-k
  // places after the point.
  always_comb begin
    lead_c = 4'd0;
    ftop_c = 4'd0;
    fnz_c = 1'b0;
    for (int k = 0; k < INT_DIGITS; k++) begin
      if (ibcd[4*k +: 4] != 4'd0) begin
        lead_c = 4'(k);
      end
    end
    for (int k = FRAC_DIGITS - 1; k >= 0; k--) begin
      if (fbcd[4*k +: 4] != 4'd0) begin
        ftop_c = frac_digits - 4'd1 - 4'(k);
        fnz_c = 1'b1;
      end
    end
  end

  // The fraction digit at position fidx from the decimal point. fidx is
  // counted from the point, so turn it back into a BCD digit number.
  logic [3:0] fdig;
  logic [3:0] fpos;
  assign fpos = frac_digits - 4'd1 - fidx;

  always_comb begin
    fdig = 4'd0;
    for (int k = 0; k < FRAC_DIGITS; k++) begin
      if (fpos == 4'(k)) begin
        fdig = fbcd[4*k +: 4];
      end
    end
  end

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:   taken = 1'b0;
      C_ALWAYS:  taken = 1'b1;
      C_NOSTART: taken = !start;
      C_CNT_NZ:  taken = (cnt != '0);
      C_LIDX_NZ: taken = (lidx != 4'd0);
      C_FZ:      taken = !fnz;
      C_FIDX_NZ: taken = (fidx != ftop);
      default:   taken = 1'b0;
    endcase
    pc_next = taken ? ctl.target : pc + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 4'd0;
      char_valid <= 1'b0;
      frac_digits <= 4'd2;
    end else begin
      pc <= pc_next;
      char_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        frac_digits <= (cfg_data > 4'(MAX_PREC)) ? 4'(MAX_PREC) : cfg_data;
      end
      unique case (ctl.op)
        OP_IDLE: begin
          if (start) begin
            neg <= is_negative;
            ip <= magnitude[FRAC_BITS +: INT_BITS];
            fr <= magnitude[FRAC_BITS-1:0];
          end
        end
        OP_MUL: begin
          prod <= PW'(fr) * PW'(sc);
        end
        OP_ROUND: begin
          isrc <= NSTEP'(ipart);
          fsrc <= NSTEP'(fpart);
          ibcd <= '0;
          fbcd <= '0;
          cnt <= CNT_W'(NSTEP - 1);
        end
        OP_DABBLE: begin
          ibcd <= {ibcd_adj[4*INT_DIGITS-2:0], isrc[NSTEP-1]};
          fbcd <= {fbcd_adj[4*FRAC_DIGITS-2:0], fsrc[NSTEP-1]};
          isrc <= {isrc[NSTEP-2:0], 1'b0};
          fsrc <= {fsrc[NSTEP-2:0], 1'b0};
          cnt <= cnt - CNT_W'(1);
        end
        OP_SCAN: begin
          lidx <= lead_c;
          ftop <= ftop_c;
          fnz <= fnz_c;
          fidx <= 4'd0;
        end
        OP_SIGN: begin
          if (neg) begin
            char_valid <= 1'b1;
            char_code <= CH_MINUS;
            last_char <= 1'b0;
          end
        end
        OP_INT: begin
          char_valid <= 1'b1;
          char_code <= CH_ZERO + {3'b000, ibcd[4*lidx +: 4]};
          last_char <= (lidx == 4'd0) && !fnz;
          lidx <= lidx - 4'd1;
        end
        OP_DOT: begin
          if (fnz) begin
            char_valid <= 1'b1;
            char_code <= CH_DOT;
            last_char <= 1'b0;
          end
        end
        OP_FRAC: begin
          char_valid <= 1'b1;
          char_code <= CH_ZERO + {3'b000, fdig};
          last_char <= (fidx == ftop);
          fidx <= fidx + 4'd1;
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_then_gap: assert property (@(posedge clk) disable iff (rst)
    char_valid && last_char |=> !char_valid)
    else $error("character emitted right after the last character");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted start did not make the block busy");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !char_valid)
    else $error("character emitted while idle");

  a_cfg_clamp: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> frac_digits <= 4'(MAX_PREC))
    else $error("precision register holds more than nine places");
`endif

endmodule
